// ----- src/lmac_pkg.sv -----
// Shared types and constants for the 4-bit activation by 8-bit weight linear layer.
package lmac_pkg;

  localparam int LANES           = 8;
  localparam int ACT_BITS        = 4;
  localparam int WEIGHT_BITS     = 8;
  localparam int SUM_BITS        = 32;
  localparam int INDEX_BITS      = 16;
  localparam int VLEN_BITS       = 11;
  localparam int CFG_DATA_BITS   = 16;
  localparam int USED_BITS       = $clog2(LANES + 1);
  localparam int LANE_SHIFT      = 3;
  localparam int PROD_BITS       = ACT_BITS + 1 + WEIGHT_BITS;
  localparam int PSUM_BITS       = PROD_BITS + LANE_SHIFT;
  localparam int MAX_VECTOR_DEF  = 1024;

  localparam logic [VLEN_BITS-1:0]  VLEN_RESET   = VLEN_BITS'(8);
  localparam logic [INDEX_BITS-1:0] NCOUNT_RESET = INDEX_BITS'(1);

  // Item kinds.
  localparam logic KIND_ACT    = 1'b0;
  localparam logic KIND_WEIGHT = 1'b1;

  // Configuration register indexes.
  localparam logic REG_VECTOR_LENGTH = 1'b0;
  localparam logic REG_NEURON_COUNT  = 1'b1;

  typedef logic signed [WEIGHT_BITS-1:0] weight_t;
  typedef weight_t weight_vec_t [LANES];

  // Per-item control that travels down the datapath with a weight group.
  typedef struct packed {
    logic                  valid;
    logic [USED_BITS-1:0]  used;
    logic                  row_end;
    logic                  last;
    logic [INDEX_BITS-1:0] index;
  } step_t;

endpackage

// ----- src/linear_layer_u4_act_i8_weight_mac_unit.sv -----
// Top level of the linear layer: unsigned 4-bit activations times signed 8-bit weights.
//
// Usage: the block is a command-style unit. A transaction is accepted at a rising
// clock edge where start is high and busy is low; busy is always low, so one item
// can be accepted in every cycle. kind selects the item: an activation load writes
// act_word (eight nibbles, low nibble first) at the next word of the store, and a
// weight group feeds lanes w0..w7 into the dot product of the current neuron.
// When a row of vector_length elements (rounded down to even, at most MAX_VECTOR)
// is complete, result_valid is high for exactly one cycle with neuron_sum, neuron_index
// and last (set on the final neuron of the pass). The receiver cannot stall; each
// result must be taken in the cycle it is shown. After the last neuron the load
// pointer returns to word zero so the next pass loads a fresh vector.
// Pipeline: a closing weight group passes three register stages (store read, lane
// multiply and partial sum, accumulate) before its result is on the ports.
// Throughput is one item per cycle, set by the single store read port and the
// single accumulator.
// Configuration: cfg_write with cfg_index selects vector_length (0) or
// neuron_count (1); write only while no transaction is in flight.
// Reset (rst, synchronous) restores vector_length 8 and neuron_count 1 and clears
// all counters and the accumulator; store contents are undefined until written.
module linear_layer_u4_act_i8_weight_mac_unit import lmac_pkg::*; #(
  parameter int MAX_VECTOR = MAX_VECTOR_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind,
  input  logic [SUM_BITS-1:0]           act_word,
  input  logic signed [WEIGHT_BITS-1:0] w0,
  input  logic signed [WEIGHT_BITS-1:0] w1,
  input  logic signed [WEIGHT_BITS-1:0] w2,
  input  logic signed [WEIGHT_BITS-1:0] w3,
  input  logic signed [WEIGHT_BITS-1:0] w4,
  input  logic signed [WEIGHT_BITS-1:0] w5,
  input  logic signed [WEIGHT_BITS-1:0] w6,
  input  logic signed [WEIGHT_BITS-1:0] w7,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  output logic                          result_valid,
  output logic signed [SUM_BITS-1:0]    neuron_sum,
  output logic [INDEX_BITS-1:0]         neuron_index,
  output logic                          last
);

  // The store holds the whole vector as packed words.
  localparam int DEPTH = (MAX_VECTOR + LANES - 1) / LANES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                        accept;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [SUM_BITS-1:0]         rd_data;
  step_t                       step_issue;
  step_t                       step_acc;
  weight_vec_t                 weights;
  logic signed [PSUM_BITS-1:0] psum;

  // Every stage is ready each cycle, so the unit never pushes back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign weights[0] = w0;
  assign weights[1] = w1;
  assign weights[2] = w2;
  assign weights[3] = w3;
  assign weights[4] = w4;
  assign weights[5] = w5;
  assign weights[6] = w6;
  assign weights[7] = w7;

  // Sequencing: counters, configuration and store addressing for each transaction.
  lmac_ctrl #(
    .MAX_VECTOR (MAX_VECTOR),
    .DEPTH      (DEPTH),
    .AW         (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .kind      (kind),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .step      (step_issue)
  );

  // A weight group reads its activation word in the cycle it is accepted.
  lmac_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (act_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Eight lane products reduced to one registered partial sum.
  lmac_dot u_dot (
    .clk      (clk),
    .rst      (rst),
    .step_in  (step_issue),
    .weights  (weights),
    .act_data (rd_data),
    .step_out (step_acc),
    .psum     (psum)
  );

  // Wrapping 32-bit accumulation and the result strobe.
  lmac_acc u_acc (
    .clk          (clk),
    .rst          (rst),
    .step         (step_acc),
    .psum         (psum),
    .result_valid (result_valid),
    .neuron_sum   (neuron_sum),
    .neuron_index (neuron_index),
    .last         (last)
  );

endmodule

// ----- src/lmac_store.sv -----
// Activation word store: one write port, one registered read port.
module lmac_store import lmac_pkg::*; #(
  parameter int DEPTH = MAX_VECTOR_DEF / LANES,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  logic [SUM_BITS-1:0] wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output logic [SUM_BITS-1:0] rd_data
);

  logic [SUM_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lmac_ctrl.sv -----
// Configuration registers, row and neuron sequencing, and store addressing.
module lmac_ctrl import lmac_pkg::*; #(
  parameter int MAX_VECTOR = MAX_VECTOR_DEF,
  parameter int DEPTH      = (MAX_VECTOR + LANES - 1) / LANES,
  parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     kind,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  output step_t                    step
);

  localparam int PW = $clog2(MAX_VECTOR + 1);
  localparam int LW = (PW > VLEN_BITS) ? PW : VLEN_BITS;

  logic [VLEN_BITS-1:0]  vector_length;
  logic [INDEX_BITS-1:0] neuron_count;
  logic [AW-1:0]         load_pointer;
  logic [PW-1:0]         position;
  logic [INDEX_BITS-1:0] neuron_counter;

  logic [LW-1:0]         len_sat;
  logic [PW-1:0]         len;
  logic [PW-1:0]         rem;
  logic                  in_row;
  logic [USED_BITS-1:0]  used;
  logic                  row_end;
  logic                  is_last;
  logic [PW-1:0]         word_idx;
  logic                  take_act;
  logic                  take_weight;

  always_comb begin
    len_sat = (LW'(vector_length) > LW'(MAX_VECTOR)) ? LW'(MAX_VECTOR) : LW'(vector_length);
    len     = PW'(len_sat) & ~PW'(1);
    in_row  = position < len;
    rem     = len - position;
    if (!in_row) begin
      used = '0;
    end else if (rem > PW'(LANES)) begin
      used = USED_BITS'(LANES);
    end else begin
      used = rem[USED_BITS-1:0];
    end
    row_end  = !in_row || (rem <= PW'(LANES));
    is_last  = ({1'b0, neuron_counter} + 17'd1) >= {1'b0, neuron_count};
    word_idx = position >> LANE_SHIFT;
  end

  assign take_act    = accept && (kind == KIND_ACT);
  assign take_weight = accept && (kind == KIND_WEIGHT);

  assign wr_en   = take_act;
  assign wr_addr = load_pointer;
  assign rd_en   = take_weight;
  assign rd_addr = AW'(word_idx);

  assign step.valid   = take_weight;
  assign step.used    = used;
  assign step.row_end = row_end;
  assign step.last    = is_last;
  assign step.index   = neuron_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= VLEN_RESET;
      neuron_count  <= NCOUNT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_VECTOR_LENGTH) begin
        vector_length <= cfg_data[VLEN_BITS-1:0];
      end else begin
        neuron_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pointer   <= '0;
      position       <= '0;
      neuron_counter <= '0;
    end else if (take_act) begin
      if (load_pointer == AW'(DEPTH - 1)) begin
        load_pointer <= '0;
      end else begin
        load_pointer <= load_pointer + AW'(1);
      end
    end else if (take_weight) begin
      if (row_end) begin
        position <= '0;
        if (is_last) begin
          neuron_counter <= '0;
          load_pointer   <= '0;
        end else begin
          neuron_counter <= neuron_counter + INDEX_BITS'(1);
        end
      end else begin
        position <= position + PW'(used);
      end
    end
  end

`ifndef ASSERT_OFF
  // Rows advance a whole group at a time, so each group starts on a word boundary.
  a_pos_aligned: assert property (@(posedge clk) disable iff (rst)
    position[LANE_SHIFT-1:0] == '0)
    else $error("element position is not word aligned");

  a_lp_range: assert property (@(posedge clk) disable iff (rst)
    load_pointer <= AW'(DEPTH - 1))
    else $error("load pointer beyond store depth");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    take_weight && row_end |=> position == '0)
    else $error("row did not restart after its closing group");

  a_load_keeps_row: assert property (@(posedge clk) disable iff (rst)
    take_act |=> $stable(position) && $stable(neuron_counter))
    else $error("activation load disturbed the row in progress");
`endif

endmodule

// ----- src/lmac_dot.sv -----
// Eight-lane multiply and partial-sum stage for one weight group.
module lmac_dot import lmac_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  step_t                      step_in,
  input  weight_vec_t                weights,
  input  logic [SUM_BITS-1:0]        act_data,
  output step_t                      step_out,
  output logic signed [PSUM_BITS-1:0] psum
);

  step_t                       step_q;
  weight_vec_t                 weights_q;
  logic signed [PROD_BITS-1:0] prod [LANES];
  logic signed [PSUM_BITS-1:0] psum_next;

  // First stage lines the weights up with the registered store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_q <= '0;
    end else begin
      step_q <= step_in;
    end
  end

  always_ff @(posedge clk) begin
    weights_q <= weights;
  end

  // Lanes beyond the used count contribute nothing.
  always_comb begin
    psum_next = '0;
    for (int i = 0; i < LANES; i++) begin
      prod[i] = $signed({1'b0, act_data[i*ACT_BITS +: ACT_BITS]}) * weights_q[i];
      if (USED_BITS'(i) < step_q.used) begin
        psum_next = psum_next + PSUM_BITS'(prod[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_out <= '0;
    end else begin
      step_out <= step_q;
    end
  end

  always_ff @(posedge clk) begin
    psum <= psum_next;
  end

endmodule

// ----- src/lmac_acc.sv -----
// Row accumulator and result register.
module lmac_acc import lmac_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  step_t                       step,
  input  logic signed [PSUM_BITS-1:0] psum,
  output logic                        result_valid,
  output logic signed [SUM_BITS-1:0]  neuron_sum,
  output logic [INDEX_BITS-1:0]       neuron_index,
  output logic                        last
);

  logic [SUM_BITS-1:0] acc;
  logic [SUM_BITS-1:0] acc_next;

  assign acc_next = acc + SUM_BITS'(psum);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= step.valid && step.row_end;
      if (step.valid) begin
        acc <= step.row_end ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step.valid && step.row_end) begin
      neuron_sum   <= $signed(acc_next);
      neuron_index <= step.index;
      last         <= step.last;
    end
  end

endmodule
